### hdl/plics_pkg.sv
// shared types, codes and helper functions of the inverse-cdf sampler
`timescale 1ns / 1ps

package plics_pkg;

   // fixed field widths
   localparam int X_WIDTH      = 32;
   localparam int Y_WIDTH      = 32;
   localparam int P_WIDTH      = 33;
   localparam int STATUS_WIDTH = 3;

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FEW       = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_UNSORTED  = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_NEGATIVE  = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_NO_AREA   = 3'd4;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 3'd5;
   localparam logic [STATUS_WIDTH-1:0] ST_NOT_READY = 3'd6;

   // iteration counts of the bit-serial units
   localparam int ITER_WIDTH     = 7;
   localparam int SQRT_STEPS     = 64;
   localparam int DIV_STEPS      = 96;
   localparam int DIV_HIGH_STEPS = 32;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_LD_START, S_LD_POINT, S_LD_LAST, S_MAC, S_STORE,
      S_BS_TEST, S_BS_CMP, S_SEG_RD0, S_SEG_RD1, S_SEG_RD2, S_PREP, S_SQRT,
      S_DEN, S_DEN_CHK, S_DIV, S_FINISH, S_LAST_RD, S_LAST_CAP, S_RESP
   } state_type;

   typedef enum logic [2:0] {
      PROD_AREA, PROD_T, PROD_NUM, PROD_ADX, PROD_SQ, PROD_TERM
   } prod_type;

   typedef enum logic [1:0] {ACC_HOLD, ACC_CLEAR, ACC_ADD} acc_op_type;

   typedef enum logic [1:0] {RA_MID, RA_SEG_PREV, RA_SEG, RA_LAST} raddr_type;

   typedef enum logic [1:0] {RES_LOAD, RES_NOT_READY, RES_SAMPLE} res_type;

   typedef struct packed {
      logic       capture;
      logic       ld_start;
      logic       ld_point;
      logic       ld_last;
      logic       mul_en;
      prod_type   prod;
      logic [1:0] part;
      acc_op_type acc_op;
      logic       store;
      logic       bs_step;
      raddr_type  raddr_sel;
      logic       seg_cap0;
      logic       seg_cap1;
      logic       prep;
      logic       last_cap;
      logic       sqrt_step;
      logic       den_calc;
      logic       div_step;
      logic       div_hi;
      logic       finish;
      logic       res_load;
      res_type    res_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic cmd_query;
      logic p_ge_one;
      logic query_ok;
      logic lo_lt_hi;
      logic den_zero;
   } dp_status_type;

   // lower rank wins
   function automatic logic [2:0] error_rank(input logic [STATUS_WIDTH-1:0] code);
      logic [2:0] rank;
      case (code)
         ST_FEW:      rank = 3'd0;
         ST_FULL:     rank = 3'd1;
         ST_UNSORTED: rank = 3'd2;
         ST_NEGATIVE: rank = 3'd3;
         default:     rank = 3'd4;
      endcase
      return rank;
   endfunction

   function automatic logic [STATUS_WIDTH-1:0] record_error(
      input logic [STATUS_WIDTH-1:0] cur, input logic [STATUS_WIDTH-1:0] code);
      logic [STATUS_WIDTH-1:0] res;
      if (cur == ST_OK || error_rank(code) < error_rank(cur)) res = code;
      else res = cur;
      return res;
   endfunction

   // number of 32x32 partial products per product
   function automatic logic [2:0] prod_parts(input prod_type prod);
      logic [2:0] n;
      case (prod)
         PROD_AREA: n = 3'd1;
         PROD_T:    n = 3'd2;
         PROD_NUM:  n = 3'd2;
         PROD_ADX:  n = 3'd1;
         PROD_SQ:   n = 3'd4;
         PROD_TERM: n = 3'd3;
         default:   n = 3'd1;
      endcase
      return n;
   endfunction

endpackage

### hdl/plics_req_if.sv
// request channel: command and point or probability payload
`timescale 1ns / 1ps

interface plics_req_if;
   import plics_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic signed [X_WIDTH-1:0]  x_value;
   logic signed [Y_WIDTH-1:0]  y_value;
   logic                       last_point;
   logic        [P_WIDTH-1:0]  probability;
   modport source (output valid, command, x_value, y_value, last_point, probability,
                   input ready);
   modport sink   (input valid, command, x_value, y_value, last_point, probability,
                   output ready);
endinterface

### hdl/plics_rsp_if.sv
// response channel: status and sampled abscissa
`timescale 1ns / 1ps

interface plics_rsp_if;
   import plics_pkg::*;
   logic                          valid;
   logic                          ready;
   logic        [STATUS_WIDTH-1:0] status;
   logic signed [X_WIDTH-1:0]      sample_x;
   modport source (output valid, status, sample_x, input ready);
   modport sink   (input valid, status, sample_x, output ready);
endinterface

### hdl/piecewise_linear_inverse_cdf_sampler.sv
// top level of the piecewise-linear inverse-cdf sampler
// load transfer: the result goes to the output register; one item at a time
// query transfer: a binary search, then the 64-step bit-serial square root
// and the 96-step restoring divider
// synchronous active-high reset empties the table; the point memories are not cleared
`timescale 1ns / 1ps

module piecewise_linear_inverse_cdf_sampler #(
   parameter int MAX_POINTS = 256
) (
   input logic         clock,
   input logic         reset,
   plics_req_if.sink   req_channel,
   plics_rsp_if.source rsp_channel
);
   import plics_pkg::*;

   // command and status between the sequencer and the datapath
   dp_cmd_type    dp_cmd;
   dp_status_type dp_stat;

   // sequencer: owns the handshakes, the multiply schedule and the iteration counts
   plics_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_ready (rsp_channel.ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   // datapath: tables in ram, one 32x32 multiplier, serial root and divider,
   // and the output register that holds a result until its transfer
   plics_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .req_command     (req_channel.command),
      .req_x_value     (req_channel.x_value),
      .req_y_value     (req_channel.y_value),
      .req_last_point  (req_channel.last_point),
      .req_probability (req_channel.probability),
      .rsp_status      (rsp_channel.status),
      .rsp_sample_x    (rsp_channel.sample_x)
   );
endmodule

### hdl/plics_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module plics_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/plics_ctrl.sv
// controller state machine of the inverse-cdf sampler
`timescale 1ns / 1ps

module plics_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output plics_pkg::dp_cmd_type   cmd,
   input  plics_pkg::dp_status_type stat
);
   import plics_pkg::*;

   state_type             state_ff, state_in;
   prod_type              prod_ff, prod_in;
   logic [2:0]            part_ff, part_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;
   res_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prod_ff      <= PROD_AREA;
         part_ff      <= '0;
         iter_ff      <= '0;
         res_ff       <= RES_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prod_ff      <= prod_in;
         part_ff      <= part_in;
         iter_ff      <= iter_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      part_in  = part_ff;
      iter_in  = iter_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.cmd_query == CMD_LOAD) begin
               res_in   = RES_LOAD;
               state_in = S_LD_START;
            end else if (!stat.query_ok) begin
               res_in   = RES_NOT_READY;
               state_in = S_RESP;
            end else if (stat.p_ge_one) begin
               res_in   = RES_SAMPLE;
               state_in = S_LAST_RD;
            end else begin
               res_in   = RES_SAMPLE;
               prod_in  = PROD_T;
               part_in  = '0;
               state_in = S_MAC;
            end
         end
         S_LD_START: state_in = S_LD_POINT;
         S_LD_POINT: begin
            prod_in  = PROD_AREA;
            part_in  = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            if (part_ff == prod_parts(prod_ff)) state_in = S_STORE;
            else part_in = part_ff + 3'd1;
         end
         S_STORE: begin
            part_in = '0;
            case (prod_ff)
               PROD_AREA: state_in = S_LD_LAST;
               PROD_T:    state_in = S_BS_TEST;
               PROD_NUM: begin
                  prod_in  = PROD_ADX;
                  state_in = S_MAC;
               end
               PROD_ADX: begin
                  prod_in  = PROD_SQ;
                  state_in = S_MAC;
               end
               PROD_SQ: begin
                  prod_in  = PROD_TERM;
                  state_in = S_MAC;
               end
               PROD_TERM: begin
                  iter_in  = '0;
                  state_in = S_SQRT;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_LD_LAST: state_in = S_RESP;
         S_BS_TEST: state_in = stat.lo_lt_hi ? S_BS_CMP : S_SEG_RD0;
         S_BS_CMP:  state_in = S_BS_TEST;
         S_SEG_RD0: state_in = S_SEG_RD1;
         S_SEG_RD1: state_in = S_SEG_RD2;
         S_SEG_RD2: state_in = S_PREP;
         S_PREP: begin
            prod_in  = PROD_NUM;
            part_in  = '0;
            state_in = S_MAC;
         end
         S_SQRT: begin
            if (iter_ff == ITER_WIDTH'(SQRT_STEPS - 1)) state_in = S_DEN;
            else iter_in = iter_ff + 1'b1;
         end
         S_DEN: state_in = S_DEN_CHK;
         S_DEN_CHK: begin
            if (stat.den_zero) begin
               state_in = S_FINISH;
            end else begin
               iter_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (iter_ff == ITER_WIDTH'(DIV_STEPS - 1)) state_in = S_FINISH;
            else iter_in = iter_ff + 1'b1;
         end
         S_FINISH:   state_in = S_RESP;
         S_LAST_RD:  state_in = S_LAST_CAP;
         S_LAST_CAP: state_in = S_RESP;
         S_RESP: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.prod     = prod_ff;
      cmd.part     = part_ff[1:0];
      cmd.acc_op   = ACC_HOLD;
      cmd.raddr_sel = RA_MID;
      cmd.res_sel  = res_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_LD_START: cmd.ld_start = 1'b1;
         S_LD_POINT: cmd.ld_point = 1'b1;
         S_LD_LAST:  cmd.ld_last  = 1'b1;
         S_MAC: begin
            cmd.mul_en = (part_ff != prod_parts(prod_ff));
            cmd.acc_op = (part_ff == 3'd0) ? ACC_CLEAR : ACC_ADD;
         end
         S_STORE:   cmd.store = 1'b1;
         S_BS_TEST: cmd.raddr_sel = RA_MID;
         S_BS_CMP:  cmd.bs_step = 1'b1;
         S_SEG_RD0: cmd.raddr_sel = RA_SEG_PREV;
         S_SEG_RD1: begin
            cmd.raddr_sel = RA_SEG;
            cmd.seg_cap0  = 1'b1;
         end
         S_SEG_RD2: cmd.seg_cap1 = 1'b1;
         S_PREP:    cmd.prep = 1'b1;
         S_SQRT:    cmd.sqrt_step = 1'b1;
         S_DEN:     cmd.den_calc = 1'b1;
         S_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_hi   = (iter_ff < ITER_WIDTH'(DIV_HIGH_STEPS));
         end
         S_FINISH:  cmd.finish = 1'b1;
         S_LAST_RD: cmd.raddr_sel = RA_LAST;
         S_LAST_CAP: cmd.last_cap = 1'b1;
         S_RESP: begin
            cmd.res_load = slot_free;
            if (slot_free) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### hdl/plics_dp.sv
// datapath: point tables, shared multiplier, search, square root and divider
`timescale 1ns / 1ps

module plics_dp #(
   parameter int MAX_POINTS = 256
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  plics_pkg::dp_cmd_type                    cmd,
   output plics_pkg::dp_status_type                 stat,
   input  logic                                     req_command,
   input  logic signed [plics_pkg::X_WIDTH-1:0]     req_x_value,
   input  logic signed [plics_pkg::Y_WIDTH-1:0]     req_y_value,
   input  logic                                     req_last_point,
   input  logic        [plics_pkg::P_WIDTH-1:0]     req_probability,
   output logic        [plics_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic signed [plics_pkg::X_WIDTH-1:0]     rsp_sample_x
);
   import plics_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   // captured item
   logic                      cmd_ff;
   logic signed [X_WIDTH-1:0] in_x_ff;
   logic signed [Y_WIDTH-1:0] in_y_ff;
   logic                      in_last_ff;
   logic [P_WIDTH-1:0]        in_p_ff;

   // table state
   logic [CW-1:0]             count_ff;
   logic [63:0]               area_ff;
   logic [STATUS_WIDTH-1:0]   err_ff;
   logic                      ready_ff;
   logic                      closed_ff;
   logic signed [X_WIDTH-1:0] last_x_ff;
   logic [Y_WIDTH-1:0]        last_y_ff;
   logic                      area_en_ff;
   logic                      full_ff;

   // multiply-accumulate
   logic [63:0]  mul_ff;
   logic [1:0]   mul_sh_ff;
   logic [127:0] acc_ff;
   logic [31:0]  op_a, op_b;
   logic [1:0]   op_sh;
   logic [127:0] acc_addend;

   // query working registers
   logic [63:0]  t_ff;
   logic [CW-1:0] lo_ff, hi_ff;
   logic [31:0]  x0_ff, x1_ff, a_ff, b_ff, dx_ff, dd_ff;
   logic [63:0]  cprev_ff, c_ff, adx_ff;
   logic         ge_ff;
   logic [95:0]  num_ff;
   logic [127:0] sq_ff;
   logic [127:0] rad_ff;
   logic [67:0]  srem_ff;
   logic [63:0]  root_ff;
   logic [63:0]  den_ff;
   logic [95:0]  dvd_ff;
   logic [63:0]  drem_ff, q_ff;
   logic         over_ff;
   logic [31:0]  answer_ff;
   logic [STATUS_WIDTH-1:0] rsp_status_ff;
   logic [31:0]  rsp_x_ff;

   // memories
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [63:0]   cum_wdata;
   logic [31:0]   x_rd, y_rd;
   logic [63:0]   cum_rd;

   // combinational helpers
   logic                    full_now;
   logic [STATUS_WIDTH-1:0] err_pt1, err_pt2, err_pt;
   logic [STATUS_WIDTH-1:0] err_lst1, err_lst2;
   logic [31:0]             dx_ld, ysum_ld;
   logic [63:0]             area_new;
   logic [CW:0]             mid_sum;
   logic [CW-1:0]           mid, cnt_m1, seg_a, seg_i, seg_im1;
   logic [127:0]            disc;
   logic [67:0]             rem2, trial;
   logic [63:0]             drem_sh;
   logic                    take;
   logic [63:0]             dx64, z_raw, z_clip;

   plics_ram #(.WIDTH(X_WIDTH), .DEPTH(MAX_POINTS)) u_ram_x (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]), .wr_data(in_x_ff),
      .rd_addr(rd_addr), .rd_data(x_rd));
   plics_ram #(.WIDTH(Y_WIDTH), .DEPTH(MAX_POINTS)) u_ram_y (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]), .wr_data(in_y_ff),
      .rd_addr(rd_addr), .rd_data(y_rd));
   plics_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram_cum (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]), .wr_data(cum_wdata),
      .rd_addr(rd_addr), .rd_data(cum_rd));

   // load checks
   always_comb begin
      full_now = (count_ff >= CW'(MAX_POINTS));
      err_pt1  = (in_y_ff < 0) ? record_error(err_ff, ST_NEGATIVE) : err_ff;
      err_pt2  = (count_ff != '0 && in_x_ff < last_x_ff) ?
                 record_error(err_pt1, ST_UNSORTED) : err_pt1;
      err_pt   = full_now ? record_error(err_ff, ST_FULL) : err_pt2;
      err_lst1 = (count_ff < CW'(2)) ? record_error(err_ff, ST_FEW) : err_ff;
      err_lst2 = (err_lst1 == ST_OK && area_ff == '0) ?
                 record_error(err_lst1, ST_NO_AREA) : err_lst1;
      dx_ld    = 32'(in_x_ff - last_x_ff);
      ysum_ld  = 32'(in_y_ff) + last_y_ff;
      area_new = area_en_ff ? area_ff + acc_ff[63:0] : area_ff;
      wr_en    = cmd.store && cmd.prod == PROD_AREA && !full_ff;
      cum_wdata = (count_ff != '0) ? area_new : '0;
   end

   // operand selection for the shared multiplier
   always_comb begin
      op_a  = '0;
      op_b  = '0;
      op_sh = 2'd0;
      case (cmd.prod)
         PROD_AREA: begin
            op_a = dx_ld;
            op_b = ysum_ld;
         end
         PROD_T: begin
            op_a  = cmd.part[0] ? area_ff[63:32] : area_ff[31:0];
            op_b  = in_p_ff[31:0];
            op_sh = {1'b0, cmd.part[0]};
         end
         PROD_NUM: begin
            op_a  = cmd.part[0] ? c_ff[63:32] : c_ff[31:0];
            op_b  = dx_ff;
            op_sh = {1'b0, cmd.part[0]};
         end
         PROD_ADX: begin
            op_a = a_ff;
            op_b = dx_ff;
         end
         PROD_SQ: begin
            op_a  = cmd.part[1] ? adx_ff[63:32] : adx_ff[31:0];
            op_b  = cmd.part[0] ? adx_ff[63:32] : adx_ff[31:0];
            op_sh = (cmd.part == 2'd0) ? 2'd0 : (cmd.part == 2'd3) ? 2'd2 : 2'd1;
         end
         PROD_TERM: begin
            case (cmd.part)
               2'd0:    op_a = num_ff[31:0];
               2'd1:    op_a = num_ff[63:32];
               default: op_a = num_ff[95:64];
            endcase
            op_b  = dd_ff;
            op_sh = cmd.part;
         end
         default: ;
      endcase
      case (mul_sh_ff)
         2'd0:    acc_addend = {64'd0, mul_ff};
         2'd1:    acc_addend = {32'd0, mul_ff, 32'd0};
         default: acc_addend = {mul_ff, 64'd0};
      endcase
   end

   // search and segment addressing
   always_comb begin
      mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid     = mid_sum[CW:1];
      cnt_m1  = count_ff - CW'(1);
      seg_a   = (lo_ff > cnt_m1) ? cnt_m1 : lo_ff;
      seg_i   = (seg_a == '0) ? CW'(1) : seg_a;
      seg_im1 = seg_i - CW'(1);
      case (cmd.raddr_sel)
         RA_MID:      rd_addr = mid[AW-1:0];
         RA_SEG_PREV: rd_addr = seg_im1[AW-1:0];
         RA_SEG:      rd_addr = seg_i[AW-1:0];
         RA_LAST:     rd_addr = cnt_m1[AW-1:0];
         default:     rd_addr = mid[AW-1:0];
      endcase
   end

   // discriminant, root step, divide step, final offset
   always_comb begin
      if (ge_ff) disc = sq_ff + acc_ff;
      else if (acc_ff > sq_ff) disc = '0;
      else disc = sq_ff - acc_ff;
      rem2    = {srem_ff[65:0], rad_ff[127:126]};
      trial   = {2'b00, root_ff, 2'b01};
      drem_sh = {drem_ff[62:0], dvd_ff[95]};
      take    = drem_ff[63] || (drem_sh >= den_ff);
      dx64    = {32'd0, dx_ff};
      if (den_ff == '0) z_raw = dx64 >> 1;
      else if (over_ff) z_raw = '1;
      else z_raw = q_ff;
      z_clip  = (z_raw > dx64) ? dx64 : z_raw;
   end

   // control state of the table
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         area_ff   <= '0;
         err_ff    <= ST_OK;
         ready_ff  <= 1'b0;
         closed_ff <= 1'b0;
      end else begin
         if (cmd.ld_start) begin
            ready_ff <= 1'b0;
            if (closed_ff) begin
               count_ff  <= '0;
               area_ff   <= '0;
               err_ff    <= ST_OK;
               closed_ff <= 1'b0;
            end
         end
         if (cmd.ld_point) begin
            err_ff <= err_pt;
         end
         if (cmd.store && cmd.prod == PROD_AREA && !full_ff) begin
            area_ff  <= area_new;
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.ld_last && in_last_ff) begin
            err_ff    <= err_lst2;
            ready_ff  <= (err_lst2 == ST_OK);
            closed_ff <= 1'b1;
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff     <= req_command;
         in_x_ff    <= req_x_value;
         in_y_ff    <= req_y_value;
         in_last_ff <= req_last_point;
         in_p_ff    <= req_probability;
      end
      if (cmd.ld_point) begin
         full_ff    <= full_now;
         area_en_ff <= !full_now && count_ff != '0 && err_pt2 == ST_OK;
      end
      if (cmd.mul_en) begin
         mul_ff    <= 64'(op_a) * 64'(op_b);
         mul_sh_ff <= op_sh;
      end
      case (cmd.acc_op)
         ACC_CLEAR: acc_ff <= '0;
         ACC_ADD:   acc_ff <= acc_ff + acc_addend;
         default:   ;
      endcase
      if (cmd.store) begin
         case (cmd.prod)
            PROD_AREA: begin
               if (!full_ff) begin
                  last_x_ff <= in_x_ff;
                  last_y_ff <= in_y_ff;
               end
            end
            PROD_T: begin
               t_ff  <= acc_ff[95:32];
               lo_ff <= '0;
               hi_ff <= count_ff;
            end
            PROD_NUM: num_ff <= acc_ff[95:0];
            PROD_ADX: adx_ff <= acc_ff[63:0];
            PROD_SQ:  sq_ff  <= acc_ff;
            PROD_TERM: begin
               rad_ff  <= disc;
               srem_ff <= '0;
               root_ff <= '0;
            end
            default: ;
         endcase
      end
      if (cmd.bs_step) begin
         if (cum_rd < t_ff) lo_ff <= mid + CW'(1);
         else hi_ff <= mid;
      end
      if (cmd.seg_cap0) begin
         x0_ff    <= x_rd;
         a_ff     <= y_rd;
         cprev_ff <= cum_rd;
      end
      if (cmd.seg_cap1) begin
         x1_ff <= x_rd;
         b_ff  <= y_rd;
      end
      if (cmd.prep) begin
         dx_ff <= x1_ff - x0_ff;
         c_ff  <= (t_ff > cprev_ff) ? t_ff - cprev_ff : '0;
         ge_ff <= (b_ff >= a_ff);
         dd_ff <= (b_ff >= a_ff) ? b_ff - a_ff : a_ff - b_ff;
      end
      if (cmd.sqrt_step) begin
         rad_ff <= rad_ff << 2;
         if (rem2 >= trial) begin
            srem_ff <= rem2 - trial;
            root_ff <= {root_ff[62:0], 1'b1};
         end else begin
            srem_ff <= rem2;
            root_ff <= {root_ff[62:0], 1'b0};
         end
      end
      if (cmd.den_calc) begin
         den_ff  <= adx_ff + root_ff;
         dvd_ff  <= num_ff;
         drem_ff <= '0;
         q_ff    <= '0;
         over_ff <= 1'b0;
      end
      if (cmd.div_step) begin
         dvd_ff  <= dvd_ff << 1;
         drem_ff <= take ? drem_sh - den_ff : drem_sh;
         q_ff    <= {q_ff[62:0], take};
         over_ff <= over_ff | (take & cmd.div_hi);
      end
      if (cmd.last_cap) answer_ff <= x_rd;
      if (cmd.finish)   answer_ff <= x0_ff + z_clip[31:0];
      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_LOAD: begin
               rsp_status_ff <= err_ff;
               rsp_x_ff      <= '0;
            end
            RES_NOT_READY: begin
               rsp_status_ff <= ST_NOT_READY;
               rsp_x_ff      <= '0;
            end
            RES_SAMPLE: begin
               rsp_status_ff <= ST_OK;
               rsp_x_ff      <= answer_ff;
            end
            default: begin
               rsp_status_ff <= ST_NOT_READY;
               rsp_x_ff      <= '0;
            end
         endcase
      end
   end

   always_comb begin
      stat.cmd_query = cmd_ff;
      stat.p_ge_one  = in_p_ff[P_WIDTH-1];
      stat.query_ok  = ready_ff && (count_ff >= CW'(2));
      stat.lo_lt_hi  = (lo_ff < hi_ff);
      stat.den_zero  = (den_ff == '0);
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_sample_x = rsp_x_ff;
endmodule

### tb/sv/plics_tb_if.sv
// testbench note: the channel interfaces come with the rtl; this file holds the stimulus item and result types
`timescale 1ns / 1ps

package plics_tb_pkg;
   import plics_pkg::*;

   typedef struct {
      logic                      command;
      logic signed [X_WIDTH-1:0] x_value;
      logic signed [Y_WIDTH-1:0] y_value;
      logic                      last_point;
      logic        [P_WIDTH-1:0] probability;
   } sampler_item_t;

   typedef struct {
      logic [STATUS_WIDTH-1:0]   status;
      logic signed [X_WIDTH-1:0] sample_x;
   } sampler_result_t;
endpackage

### tb/sv/tb.sv
// self-checking testbench of the piecewise-linear inverse-cdf sampler
`timescale 1ns / 1ps

module tb;
   import plics_pkg::*;
   import plics_tb_pkg::*;

   localparam int TABLE_DEPTH = 256;

   int fail_count = 0;

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // scoreboard: its own copy of the density table, predicts one result per transfer
   class density_scoreboard;
      logic [31:0] grid_x [TABLE_DEPTH];
      logic [31:0] dens_y [TABLE_DEPTH];
      logic [63:0] cum_area [TABLE_DEPTH];
      int unsigned n_points;
      logic [63:0] total_area;
      logic [2:0]  err_code;
      bit          ready_flag;
      bit          closed;
      sampler_result_t pending [$];

      function void clear();
         n_points = 0; total_area = 0; err_code = ST_OK;
         ready_flag = 0; closed = 0; pending.delete();
      endfunction

      function int rank_of(logic [2:0] code);
         case (code)
            ST_FEW:      return 0;
            ST_FULL:     return 1;
            ST_UNSORTED: return 2;
            ST_NEGATIVE: return 3;
            default:     return 4;
         endcase
      endfunction

      function void flag(logic [2:0] code);
         if (err_code == ST_OK || rank_of(code) < rank_of(err_code)) err_code = code;
      endfunction

      function logic [63:0] int_sqrt(logic [127:0] v);
         logic [63:0] r;
         logic [63:0] cand;
         r = 0;
         for (int b = 63; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= v) r = cand;
         end
         return r;
      endfunction

      function logic [31:0] percentile(logic [32:0] p);
         int unsigned lo, hi, mid, i;
         logic [63:0] t, c, dx, a, b, adx, den, z, dy;
         logic [127:0] num, sq, term, disc, q;
         longint x0, x1;
         if (p[32]) return grid_x[n_points-1];
         t = (total_area >> 32) * {31'd0, p} + ((({32'd0, total_area[31:0]}) * p) >> 32);
         lo = 0; hi = n_points;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (cum_area[mid] < t) lo = mid + 1; else hi = mid;
         end
         i = lo;
         if (i > n_points - 1) i = n_points - 1;
         if (i < 1) i = 1;
         x0 = longint'($signed(grid_x[i-1]));
         x1 = longint'($signed(grid_x[i]));
         dx = x1 - x0;
         a = dens_y[i-1]; b = dens_y[i];
         c = t > cum_area[i-1] ? t - cum_area[i-1] : 0;
         num = {64'd0, c} * {64'd0, dx};
         adx = a * dx;
         sq = {64'd0, adx} * {64'd0, adx};
         dy = b >= a ? b - a : a - b;
         term = num * {64'd0, dy};
         if (b >= a) disc = sq + term;
         else if (term > sq) disc = 0;
         else disc = sq - term;
         den = adx + int_sqrt(disc);
         if (den == 0) z = dx >> 1;
         else begin
            q = num / {64'd0, den};
            z = q[127:64] != 0 ? '1 : q[63:0];
         end
         if (z > dx) z = dx;
         return 32'(x0 + longint'(z));
      endfunction

      // accepted request transfer: update the table copy and queue the result
      function void note_request(sampler_item_t it);
         sampler_result_t r;
         longint sx, sy, px;
         r.sample_x = 0;
         if (it.command == CMD_LOAD) begin
            if (closed) begin
               n_points = 0; total_area = 0; err_code = ST_OK; closed = 0;
            end
            ready_flag = 0;
            if (n_points >= TABLE_DEPTH) flag(ST_FULL);
            else begin
               sx = longint'(it.x_value);
               sy = longint'(it.y_value);
               if (sy < 0) flag(ST_NEGATIVE);
               if (n_points > 0) begin
                  px = longint'($signed(grid_x[n_points-1]));
                  if (sx < px) flag(ST_UNSORTED);
                  if (err_code == ST_OK)
                     total_area += 64'(sx - px) * (64'(sy) + {32'd0, dens_y[n_points-1]});
               end
               grid_x[n_points] = it.x_value;
               dens_y[n_points] = it.y_value;
               cum_area[n_points] = n_points > 0 ? total_area : 0;
               n_points++;
            end
            if (it.last_point) begin
               if (n_points < 2) flag(ST_FEW);
               if (err_code == ST_OK && total_area == 0) flag(ST_NO_AREA);
               ready_flag = (err_code == ST_OK);
               closed = 1;
            end
            r.status = err_code;
         end else if (!ready_flag || n_points < 2) r.status = ST_NOT_READY;
         else begin
            r.status = ST_OK;
            r.sample_x = percentile(it.probability);
         end
         pending.insert(pending.size(), r);
      endfunction

      task check_result(logic [2:0] st, logic [31:0] sx);
         sampler_result_t e;
         if (pending.size() == 0) begin
            report_mismatch("response with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (st !== e.status)
            report_mismatch($sformatf("status got %0d want %0d", st, e.status));
         if (sx !== e.sample_x)
            report_mismatch($sformatf("sample_x got %h want %h", sx, e.sample_x));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   int   src_idle_pct = 0;
   int   snk_idle_pct = 0;
   bit   snk_hold = 0;

   plics_req_if req_ch();
   plics_rsp_if rsp_ch();

   piecewise_linear_inverse_cdf_sampler dut (
      .clock(clock), .reset(reset), .req_channel(req_ch.sink), .rsp_channel(rsp_ch.source)
   );

   density_scoreboard sb = new();

   always #5 clock = ~clock;

   // one request transfer, with random idle cycles ahead of it
   task automatic send_item(sampler_item_t it);
      @(posedge clock);
      while ($urandom_range(99) < src_idle_pct) @(posedge clock);
      req_ch.valid       <= 1;
      req_ch.command     <= it.command;
      req_ch.x_value     <= it.x_value;
      req_ch.y_value     <= it.y_value;
      req_ch.last_point  <= it.last_point;
      req_ch.probability <= it.probability;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(it);
      req_ch.valid <= 0;
   endtask

   task automatic send_point(int x, int y, bit last);
      sampler_item_t it;
      it.command = CMD_LOAD; it.x_value = x; it.y_value = y;
      it.last_point = last; it.probability = 33'($urandom);
      send_item(it);
   endtask

   task automatic send_query(logic [32:0] p);
      sampler_item_t it;
      it.command = CMD_QUERY; it.x_value = $urandom; it.y_value = $urandom;
      it.last_point = 1'($urandom_range(1)); it.probability = p;
      send_item(it);
   endtask

   function automatic logic [32:0] rand_prob();
      case ($urandom_range(9))
         0: return 33'd0;
         1: return 33'h1_0000_0000;
         2: return {1'b1, 32'($urandom)};
         3: return 33'h0_FFFF_FFFF;
         default: return {1'b0, 32'($urandom)};
      endcase
   endfunction

   // a density with random content, with bad points only when allow_bad is set; small tables mostly
   task automatic load_random_table(int unsigned n_pts, bit allow_bad);
      int x;
      int y;
      x = $urandom_range(3) == 0 ? int'($urandom) : $urandom_range(200000) - 100000;
      for (int k = 0; k < n_pts; k++) begin
         case ($urandom_range(5))
            0: y = 0;
            1: y = $urandom;
            2: y = $urandom_range(100);
            default: y = $urandom_range(1 << 20);
         endcase
         y = y & 32'h7FFF_FFFF;
         if (allow_bad && $urandom_range(15) == 0) y = -$urandom_range(1000) - 1;
         send_point(x, y, k == n_pts - 1);
         if (allow_bad && $urandom_range(15) == 0) x = x - $urandom_range(1000) - 1;
         else if ($urandom_range(7) == 0) x = x;
         else x = x + $urandom_range(1 << $urandom_range(20));
      end
   endtask

   // response side: random stalls plus the long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.status, rsp_ch.sample_x);
         rsp_ch.ready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
      end
   end

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      req_ch.valid = 0; req_ch.command = CMD_LOAD; req_ch.x_value = 0; req_ch.y_value = 0;
      req_ch.last_point = 0; req_ch.probability = 0;
      sb.clear();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: query before any table, too few points, errors, extremes
      send_query(33'd0);
      send_point(0, 100, 1);
      send_point(10, 5, 0); send_point(5, 5, 0); send_point(20, -1, 1);
      send_point(0, 0, 0); send_point(65536, 0, 1);
      send_query(33'h0_8000_0000);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
      send_query(33'd0); send_query(33'h0_FFFF_FFFF); send_query(33'h1_FFFF_FFFF);
      send_point(0, 0, 0); send_point(65536, 1000, 0); send_point(65536, 1000, 0);
      send_point(131072, 0, 1);
      send_query(33'h0_4000_0000); send_query(33'h1_0000_0000); send_query(33'h0_C000_0000);
      send_point(0, 5, 0);
      send_query(33'd1);

      // full table, then one point past it
      for (int k = 0; k <= TABLE_DEPTH; k++) send_point(k * 100, k, k == TABLE_DEPTH);
      for (int k = 0; k < TABLE_DEPTH; k++) send_point(k * 100, k + 1, k == TABLE_DEPTH - 1);
      send_query(rand_prob()); send_query(33'h0_FFFF_FFFF);
      wait_drained();

      // long receiver hold-off while requests keep coming
      fork
         begin
            snk_hold = 1;
            repeat (600) @(posedge clock);
            snk_hold = 0;
         end
         for (int k = 0; k < 12; k++) send_query(rand_prob());
      join

      for (int phase = 0; phase < 3; phase++) begin
         src_idle_pct = phase == 0 ? 30 : phase == 1 ? 74 : 0;
         snk_idle_pct = phase == 0 ? 74 : phase == 1 ? 30 : 0;
         for (int blk = 0; blk < 30; blk++) begin
            if ($urandom_range(9) == 0) load_random_table($urandom_range(1, 3), 1);
            else load_random_table($urandom_range(9) == 0 ? $urandom_range(2, 64)
                                                          : $urandom_range(2, 8),
                                   $urandom_range(4) == 0);
            repeat ($urandom_range(2, 14)) send_query(rand_prob());
         end
      end

      wait_drained();
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   // watchdog: reports a failure and ends the run if it is still going at the time limit
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

### files.f
hdl/plics_pkg.sv
hdl/plics_req_if.sv
hdl/plics_rsp_if.sv
hdl/plics_ram.sv
hdl/plics_ctrl.sv
hdl/plics_dp.sv
hdl/piecewise_linear_inverse_cdf_sampler.sv
tb/sv/plics_tb_if.sv
tb/sv/tb.sv
